@@ rtl/ritoa_pkg.sv @@
package ritoa_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_READ,
    ST_LOAD,
    ST_ZERO
  } state_t;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_RADIX      = 2'd0;
  localparam logic [1:0] REG_CHARS_LOW  = 2'd1;
  localparam logic [1:0] REG_CHARS_HIGH = 2'd2;

  localparam int RADIX_W  = 5;
  localparam int DIGIT_W  = 4;
  localparam int CHAR_W   = 8;
  localparam int DIV_STEPS = 8;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [63:0] CHARS_LOW_RESET  = 64'h3736353433323130;
  localparam logic [63:0] CHARS_HIGH_RESET = 64'h6665646362613938;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;

  typedef struct packed {
    logic done;
    logic quot_zero;
  } div_stat_t;

endpackage

@@ rtl/radix_integer_to_ascii.sv @@
// A nonzero value is divided digit by digit in the shared divider (8 quotient bits a
//   cycle), then each character comes out of the digit memory through ST_READ and
//   ST_LOAD, and ST_LOAD waits while the output is stalled.
// One value is converted at a time; a new one is taken only back in idle.
// A zero value goes through ST_ZERO, which loads '0' once the output slot is free.
// Reset (rst_n, synchronous, active low): radix 10, table "0123456789abcdef", idle.
module radix_integer_to_ascii #(
  parameter int VALUE_WIDTH = 64,
  parameter int MAX_DIGITS  = 64,
  parameter int MAX_RADIX   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input request
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] value
  // Result request
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] character
  output logic        out_tlast,  // last digit of the number
  // Configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [63:0] cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_DIGITS);
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DIGITS);
  localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);
  localparam logic [ritoa_pkg::RADIX_W-1:0] RADIX_MAX = ritoa_pkg::RADIX_W'(MAX_RADIX);

  ritoa_pkg::state_t state_r, state_nxt;

  // Configuration registers
  logic [ritoa_pkg::RADIX_W-1:0] radix_r;
  logic [63:0]                   chars_lo_r;
  logic [63:0]                   chars_hi_r;
  logic [ritoa_pkg::RADIX_W-1:0] radix_clamped;

  // Digit count: counts up while dividing, down while emitting
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_inc;

  // Digit store, least significant digit at entry 0
  logic [ritoa_pkg::DIGIT_W-1:0] digit_mem [MAX_DIGITS];
  logic [ritoa_pkg::DIGIT_W-1:0] rd_digit_r;
  logic [IDX_W-1:0]              rd_addr;

  // Output register
  logic                          out_valid_r;
  logic [ritoa_pkg::CHAR_W-1:0]  out_char_r;
  logic                          out_last_r;

  // Divider hookup
  logic [VALUE_WIDTH-1:0]        div_dividend;
  logic [VALUE_WIDTH-1:0]        div_quot;
  logic [ritoa_pkg::DIGIT_W-1:0] div_rem;
  ritoa_pkg::div_stat_t          div_stat;

  // Control strobes
  logic in_zero;
  logic div_finish;
  logic slot_free;
  logic div_start;
  logic mem_we;
  logic mem_re;
  logic load_digit;
  logic load_zero;

  logic [127:0] chars_all;
  logic [6:0]   char_sel;

  assign in_zero    = (in_tdata[VALUE_WIDTH-1:0] == '0);
  assign cnt_inc    = cnt_r + 1'b1;
  // Stop dividing once the quotient is gone or the store is full
  assign div_finish = div_stat.quot_zero || (cnt_inc == MAX_CNT);
  assign slot_free  = !out_valid_r || out_tready;
  assign rd_addr    = IDX_W'(cnt_r - 1'b1);

  // First digit divides the input value, later ones the previous quotient
  assign div_dividend = (state_r == ritoa_pkg::ST_IDLE) ? in_tdata[VALUE_WIDTH-1:0] : div_quot;

  ritoa_div #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .radix     (radix_r),
    .quotient  (div_quot),
    .remainder (div_rem),
    .stat      (div_stat)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ritoa_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = in_zero ? ritoa_pkg::ST_ZERO : ritoa_pkg::ST_DIVIDE;
        end
      end
      ritoa_pkg::ST_DIVIDE: begin
        if (div_stat.done && div_finish) begin
          state_nxt = ritoa_pkg::ST_READ;
        end
      end
      ritoa_pkg::ST_READ: begin
        state_nxt = ritoa_pkg::ST_LOAD;
      end
      ritoa_pkg::ST_LOAD: begin
        if (slot_free) begin
          state_nxt = (cnt_r == ONE_CNT) ? ritoa_pkg::ST_IDLE : ritoa_pkg::ST_READ;
        end
      end
      ritoa_pkg::ST_ZERO: begin
        if (slot_free) begin
          state_nxt = ritoa_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ritoa_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_tready  = 1'b0;
    div_start  = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    load_digit = 1'b0;
    load_zero  = 1'b0;
    unique case (state_r)
      ritoa_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        div_start = in_tvalid && !in_zero;
      end
      ritoa_pkg::ST_DIVIDE: begin
        mem_we    = div_stat.done;
        div_start = div_stat.done && !div_finish;
      end
      ritoa_pkg::ST_READ: begin
        mem_re = 1'b1;
      end
      ritoa_pkg::ST_LOAD: begin
        load_digit = slot_free;
      end
      ritoa_pkg::ST_ZERO: begin
        load_zero = slot_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ritoa_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Clamp radix writes to 2..MAX_RADIX
  always_comb begin
    radix_clamped = cfg_wdata[ritoa_pkg::RADIX_W-1:0];
    priority if (radix_clamped < ritoa_pkg::RADIX_MIN) begin
      radix_clamped = ritoa_pkg::RADIX_MIN;
    end else if (radix_clamped > RADIX_MAX) begin
      radix_clamped = RADIX_MAX;
    end else begin
      radix_clamped = cfg_wdata[ritoa_pkg::RADIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r    <= ritoa_pkg::RADIX_RESET;
      chars_lo_r <= ritoa_pkg::CHARS_LOW_RESET;
      chars_hi_r <= ritoa_pkg::CHARS_HIGH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ritoa_pkg::REG_RADIX:      radix_r    <= radix_clamped;
        ritoa_pkg::REG_CHARS_LOW:  chars_lo_r <= cfg_wdata;
        ritoa_pkg::REG_CHARS_HIGH: chars_hi_r <= cfg_wdata;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Digit count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_tvalid && in_tready) begin
      cnt_r <= '0;
    end else if (mem_we) begin
      cnt_r <= cnt_inc;
    end else if (load_digit) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // Digit store: write remainders in order, read back in reverse
  always_ff @(posedge clk) begin
    if (mem_we) begin
      digit_mem[cnt_r[IDX_W-1:0]] <= div_rem;
    end
    if (mem_re) begin
      rd_digit_r <= digit_mem[rd_addr];
    end
  end

  // Digit to character through the 16-entry table
  assign chars_all = {chars_hi_r, chars_lo_r};
  assign char_sel  = {rd_digit_r, 3'b000};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_digit || load_zero) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_digit) begin
      out_char_r <= chars_all[char_sel +: ritoa_pkg::CHAR_W];
      out_last_r <= (cnt_r == ONE_CNT);
    end else if (load_zero) begin
      out_char_r <= ritoa_pkg::CHAR_ZERO;
      out_last_r <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;

endmodule

@@ rtl/ritoa_div.sv @@
module ritoa_div #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [VALUE_WIDTH-1:0]          dividend,
  input  logic [ritoa_pkg::RADIX_W-1:0]   radix,
  output logic [VALUE_WIDTH-1:0]          quotient,
  output logic [ritoa_pkg::DIGIT_W-1:0]   remainder,
  output ritoa_pkg::div_stat_t            stat
);

  localparam int CYC   = (VALUE_WIDTH + ritoa_pkg::DIV_STEPS - 1) / ritoa_pkg::DIV_STEPS;
  localparam int QW    = CYC * ritoa_pkg::DIV_STEPS;
  localparam int CNT_W = (CYC > 1) ? $clog2(CYC) : 1;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(CYC - 1);

  logic [QW-1:0]                     q_r;
  logic [ritoa_pkg::DIGIT_W-1:0]     rem_r;
  logic [CNT_W-1:0]                  cnt_r;
  logic                              busy_r;
  logic                              done_r;

  logic [QW-1:0]                     q_step;
  logic [ritoa_pkg::DIGIT_W-1:0]     rem_step;
  logic [ritoa_pkg::RADIX_W-1:0]     rem_sh;
  logic                              ge;
  logic                              last_cyc;

  // Restoring long division, eight quotient bits per cycle, MSB first
  always_comb begin
    q_step   = q_r;
    rem_step = rem_r;
    rem_sh   = '0;
    ge       = 1'b0;
    for (int i = 0; i < ritoa_pkg::DIV_STEPS; i++) begin
      rem_sh   = {rem_step, q_step[QW-1]};
      ge       = (rem_sh >= radix);
      rem_step = ge ? ritoa_pkg::DIGIT_W'(rem_sh - radix) : rem_sh[ritoa_pkg::DIGIT_W-1:0];
      q_step   = {q_step[QW-2:0], ge};
    end
  end

  assign last_cyc = busy_r && (cnt_r == LAST_CNT);

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= QW'(dividend);
      rem_r <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      q_r   <= q_step;
      rem_r <= rem_step;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= start || (busy_r && !last_cyc);
      done_r <= last_cyc && !start;
    end
  end

  assign quotient       = q_r[VALUE_WIDTH-1:0];
  assign remainder      = rem_r;
  assign stat.done      = done_r;
  assign stat.quot_zero = (q_r == '0);

endmodule

@@ rtl/ritoa_chk.sv @@
module ritoa_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [63:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("result payload changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a number is in progress");

  a_zero_char: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tdata == 64'd0) && !out_tvalid
    |=> ##1 (out_tvalid && (out_tdata == 8'h30) && out_tlast))
    else $error("zero value did not give a single '0'");

endmodule

bind radix_integer_to_ascii ritoa_chk u_ritoa_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

@@ tb/sv/radix_integer_to_ascii_test.sv @@
`timescale 1ns / 1ps

module radix_integer_to_ascii_test;

  localparam int VALUE_WIDTH = 64;
  localparam int MAX_DIGITS  = 64;
  localparam int MAX_RADIX   = 16;
  localparam logic [ritoa_pkg::RADIX_W-1:0] RADIX_TOP = ritoa_pkg::RADIX_W'(MAX_RADIX);

  // Index 3 has no register behind it; writes there must change nothing.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // Cycles to let pass once the last character has arrived, a generous
  // margin for the block to fall back to idle.
  localparam int DRAIN_CYCLES  = 16;
  // Long receiver hold-off, long enough to back the block up into its input.
  localparam int HOLD_CYCLES   = 3000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 13;

  typedef struct packed {
    logic [ritoa_pkg::CHAR_W-1:0] ch;
    logic                         last;
  } digit_char_t;

  typedef enum logic {
    ROW_WRITE,
    ROW_VALUE
  } row_kind_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_addr   = '0;
  logic [63:0] cfg_wdata  = '0;

  // Characters still owed by the block, oldest first.
  digit_char_t pending_chars[$];

  // Our own copy of the configuration registers, as the block should hold them.
  logic [ritoa_pkg::RADIX_W-1:0] model_radix      = ritoa_pkg::RADIX_RESET;
  logic [63:0]                   model_chars_low  = ritoa_pkg::CHARS_LOW_RESET;
  logic [63:0]                   model_chars_high = ritoa_pkg::CHARS_HIGH_RESET;

  // Directed stimulus, one row per register write or number.
  row_kind_t   row_kind[$];
  logic [1:0]  row_addr[$];
  logic [63:0] row_data[$];
  string       row_text[$];

  int mismatches    = 0;
  int chars_checked = 0;
  int numbers_sent  = 0;
  int phases_run    = 0;
  int burst_left    = 0;
  int radix_seen_lo = MAX_RADIX;
  int radix_seen_hi = 0;

  logic hold_req = 1'b0;
  logic hold_off = 1'b0;
  int   rx_cycle = 0;
  int   stall_mode = 0;

  radix_integer_to_ascii #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .MAX_DIGITS (MAX_DIGITS),
    .MAX_RADIX  (MAX_RADIX)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs somewhere.
  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Divide the number down by the radix, collect remainders least significant
  // first, then queue the table characters most significant first.
  function automatic void predict_digits(input logic [63:0] value);
    logic [3:0]  digits [MAX_DIGITS];
    logic [63:0] quotient;
    logic [63:0] base;
    logic [63:0] word;
    logic [3:0]  d;
    int          count;
    quotient = value;
    base     = {{(64-ritoa_pkg::RADIX_W){1'b0}}, model_radix};
    count    = 0;
    // Zero is the fixed '0', never a table lookup.
    if (quotient == 0) begin
      pending_chars.push_back('{ch: ritoa_pkg::CHAR_ZERO, last: 1'b1});
      return;
    end
    while (quotient != 0 && count < MAX_DIGITS) begin
      digits[count] = 4'(quotient % base);
      quotient      = quotient / base;
      count++;
    end
    for (int k = count; k > 0; k--) begin
      d    = digits[k-1];
      word = d[3] ? model_chars_high : model_chars_low;
      pending_chars.push_back('{ch: word[d[2:0]*8 +: 8], last: (k == 1)});
    end
  endfunction

  task automatic add_row(input row_kind_t kind, input logic [1:0] addr,
                         input logic [63:0] data, input string text);
    row_kind.push_back(kind);
    row_addr.push_back(addr);
    row_data.push_back(data);
    row_text.push_back(text);
  endtask

  // Pulse one write on the configuration port and track it in the model copy.
  task automatic write_register(input logic [1:0] addr, input logic [63:0] data);
    logic [ritoa_pkg::RADIX_W-1:0] r;
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (addr)
      ritoa_pkg::REG_RADIX: begin
        // Only the low bits count; clamp into 2..MAX_RADIX.
        r = data[ritoa_pkg::RADIX_W-1:0];
        if (r < ritoa_pkg::RADIX_MIN) r = ritoa_pkg::RADIX_MIN;
        if (r > RADIX_TOP) r = RADIX_TOP;
        model_radix = r;
        if (int'(r) < radix_seen_lo) radix_seen_lo = int'(r);
        if (int'(r) > radix_seen_hi) radix_seen_hi = int'(r);
      end
      ritoa_pkg::REG_CHARS_LOW:  model_chars_low  = data;
      ritoa_pkg::REG_CHARS_HIGH: model_chars_high = data;
      default: ;
    endcase
  endtask

  // Offer one number. Between bursts drop the request for a random gap.
  // Expected characters come from the typed text if given, else the predictor.
  task automatic send_value(input logic [63:0] value, input string text);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                : $urandom_range(1, 8);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    numbers_sent++;
    if (text.len() > 0) begin
      for (int i = 0; i < text.len(); i++)
        pending_chars.push_back('{ch: text[i], last: (i == text.len() - 1)});
    end else begin
      predict_digits(value);
    end
  endtask

  // Drop the request and hold until every owed character has come out.
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    int          w;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = '1;
      2, 3: ;
      4: v = 64'($urandom_range(0, 1000));
      5: begin
        w = $urandom_range(1, 63);
        v = v & ((64'd1 << w) - 64'd1);
      end
      6: v = 64'd1 << $urandom_range(0, 63);
      default: v = 64'($urandom);
    endcase
    return v;
  endfunction

  // Receiver: check each accepted character against the oldest expectation,
  // then pick out_tready for the next cycle from a stall pattern whose mode is
  // redrawn at random as rx_cycle runs. The long hold-off overrides the pattern.
  always @(posedge clk) begin
    digit_char_t want;
    logic        ready_next;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected character %h last %b, nothing pending",
                   out_tdata, out_tlast);
      end else begin
        want = pending_chars.pop_front();
        chars_checked++;
        if (out_tdata !== want.ch || out_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: character exp %h got %h, last exp %b got %b",
                     want.ch, out_tdata, want.last, out_tlast);
        end
      end
    end
    rx_cycle++;
    if (rx_cycle % 256 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0:       ready_next = 1'b1;
      1:       ready_next = $urandom_range(0, 1) == 0;
      2:       ready_next = $urandom_range(0, 7) != 0;
      default: ready_next = $urandom_range(0, 3) == 0;
    endcase
    out_tready <= !hold_off && ready_next;
  end

  // Long receiver hold-off, counted here once the main sequence asks for it.
  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    logic [63:0] data;

    // After reset: radix 10, table "0123456789abcdef".
    add_row(ROW_VALUE, ritoa_pkg::REG_RADIX, 64'd0, "0");
    add_row(ROW_VALUE, ritoa_pkg::REG_RADIX, 64'd1, "1");
    add_row(ROW_VALUE, ritoa_pkg::REG_RADIX, 64'd9, "9");
    add_row(ROW_VALUE, ritoa_pkg::REG_RADIX, 64'd10, "10");
    add_row(ROW_VALUE, ritoa_pkg::REG_RADIX, 64'd12345, "12345");
    add_row(ROW_VALUE, ritoa_pkg::REG_RADIX, 64'hFFFF_FFFF_FFFF_FFFF, "18446744073709551615");
    add_row(ROW_VALUE, ritoa_pkg::REG_RADIX, 64'h8000_0000_0000_0000, "");
    // Top radix.
    add_row(ROW_WRITE, ritoa_pkg::REG_RADIX, 64'd16, "");
    add_row(ROW_VALUE, ritoa_pkg::REG_RADIX, 64'hFFFF_FFFF_FFFF_FFFF, "ffffffffffffffff");
    add_row(ROW_VALUE, ritoa_pkg::REG_RADIX, 64'h0123_4567_89AB_CDEF, "123456789abcdef");
    add_row(ROW_VALUE, ritoa_pkg::REG_RADIX, 64'd0, "0");
    // Radix below two clamps to binary; all-ones and top-bit values give full 64-digit strings.
    add_row(ROW_WRITE, ritoa_pkg::REG_RADIX, 64'd0, "");
    add_row(ROW_VALUE, ritoa_pkg::REG_RADIX, 64'd5, "101");
    add_row(ROW_VALUE, ritoa_pkg::REG_RADIX, 64'hFFFF_FFFF_FFFF_FFFF, "");
    add_row(ROW_VALUE, ritoa_pkg::REG_RADIX, 64'h8000_0000_0000_0000, "");
    // Radix above the top clamps to 16, radix 1 to 2.
    add_row(ROW_WRITE, ritoa_pkg::REG_RADIX, 64'd31, "");
    add_row(ROW_VALUE, ritoa_pkg::REG_RADIX, 64'd255, "ff");
    add_row(ROW_WRITE, ritoa_pkg::REG_RADIX, 64'd1, "");
    add_row(ROW_VALUE, ritoa_pkg::REG_RADIX, 64'd2, "10");
    add_row(ROW_WRITE, ritoa_pkg::REG_RADIX, 64'd17, "");
    add_row(ROW_VALUE, ritoa_pkg::REG_RADIX, 64'd4095, "fff");
    // Upper data bits are ignored: low bits give radix 3.
    add_row(ROW_WRITE, ritoa_pkg::REG_RADIX, 64'hFFFF_FFFF_FFFF_FFE3, "");
    add_row(ROW_VALUE, ritoa_pkg::REG_RADIX, 64'd8, "22");
    // Write to the unused index: radix must stay 3.
    add_row(ROW_WRITE, REG_UNUSED, 64'hA5A5_5A5A_FFFF_0010, "");
    add_row(ROW_VALUE, ritoa_pkg::REG_RADIX, 64'd9, "100");
    // Custom table; zero still gives the fixed '0'.
    add_row(ROW_WRITE, ritoa_pkg::REG_RADIX, 64'd16, "");
    add_row(ROW_WRITE, ritoa_pkg::REG_CHARS_LOW, 64'h4847_4645_4443_4241, "");
    add_row(ROW_WRITE, ritoa_pkg::REG_CHARS_HIGH, 64'h504F_4E4D_4C4B_4A49, "");
    add_row(ROW_VALUE, ritoa_pkg::REG_RADIX, 64'hFEDC_BA98_7654_3210, "PONMLKJIHGFEDCBA");
    add_row(ROW_VALUE, ritoa_pkg::REG_RADIX, 64'd0, "0");
    // Table extremes: all-zero low half, all-ones high half.
    add_row(ROW_WRITE, ritoa_pkg::REG_CHARS_LOW, 64'h0, "");
    add_row(ROW_WRITE, ritoa_pkg::REG_CHARS_HIGH, 64'hFFFF_FFFF_FFFF_FFFF, "");
    add_row(ROW_VALUE, ritoa_pkg::REG_RADIX, 64'h0F0F_F0F0_1234_89AB, "");

    // Hold reset, then release it for good.
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed rows; register writes only once the block is idle.
    for (int i = 0; i < row_kind.size(); i++) begin
      if (row_kind[i] == ROW_WRITE) begin
        wait_drain();
        write_register(row_addr[i], row_data[i]);
      end else begin
        send_value(row_data[i], row_text[i]);
      end
    end

    // Random phases: new settings each phase, then a batch of numbers.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_drain();
      case ($urandom_range(0, 5))
        0:       data = 64'd2;
        1:       data = 64'd16;
        2:       data = 64'd10;
        3:       data = {$urandom, $urandom};
        4:       data = 64'($urandom_range(0, 31));
        default: data = 64'd8;
      endcase
      write_register(ritoa_pkg::REG_RADIX, data);
      write_register(ritoa_pkg::REG_CHARS_LOW,
                     ($urandom_range(0, 1) == 0) ? ritoa_pkg::CHARS_LOW_RESET
                                                 : {$urandom, $urandom});
      write_register(ritoa_pkg::REG_CHARS_HIGH,
                     ($urandom_range(0, 1) == 0) ? ritoa_pkg::CHARS_HIGH_RESET
                                                 : {$urandom, $urandom});
      if ($urandom_range(0, 3) == 0) write_register(REG_UNUSED, {$urandom, $urandom});
      phases_run++;
      // In one phase hold the receiver off and keep offering back to back,
      // so the block backs up and stalls its input.
      if (p == 2) begin
        hold_req   <= 1'b1;
        burst_left = 1000;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) send_value(pick_value(), "");
      if (p == 2) burst_left = 0;
    end

    // Drain the tail and give any stray output time to show up.
    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d numbers over %0d random phases, radix %0d to %0d",
             numbers_sent, phases_run, radix_seen_lo, radix_seen_hi);
    $display("Checked %0d characters, %0d mismatches", chars_checked, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
